// ===== src/cct_pkg.sv =====
// shared types and constants for the cluster chain table engine
// no dependencies; imported by cct_ram and cluster_chain_table_engine
package cct_pkg;

    localparam int ENTRY_W = 28;
    localparam int CFG_W = 12;
    localparam int CNT_W = 13;
    localparam int OP_W = 2;
    localparam int STAT_W = 2;

    localparam int DEF_CLUSTER_SLOTS = 4096;

    localparam logic [ENTRY_W-1:0] END_MARK = 28'hFFFFFF8;
    localparam logic [ENTRY_W-1:0] FIRST_DATA = 28'd2;

    localparam logic [OP_W-1:0] OP_READ = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
    localparam logic [OP_W-1:0] OP_FREE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_ARG = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CHAIN = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ENTRY_W-1:0] cluster;
        logic [ENTRY_W-1:0] entry_value;
        logic [CNT_W-1:0]   run_count;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] cluster_result;
    } rsp_t;

endpackage

// ===== src/cluster_chain_table_engine.sv =====
// Cluster allocation table engine: one request at a time, one response per request.
// After reset a clearing pass writes zero to every entry, during which no request is
// taken (cluster_count writes are always taken). A write goes through S_RESP to its
// response, a read through S_RD and S_RESP. An allocate reads one entry per cycle from
// cluster 2 upward until a run is found or entry cluster_count + 1 (at most
// CLUSTER_SLOTS - 1) has been read, then writes the chain one entry per cycle. A free
// reads and clears one link per cycle. A new request is taken while the last response
// is still waiting.
// Depends on cct_pkg and cct_ram.
module cluster_chain_table_engine #(
    parameter int CLUSTER_SLOTS = cct_pkg::DEF_CLUSTER_SLOTS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  cct_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output cct_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cct_pkg::CFG_W-1:0] cfg_data
);
    import cct_pkg::*;

    localparam int IDX_W = $clog2(CLUSTER_SLOTS);
    localparam int LAST_SLOT = CLUSTER_SLOTS - 1;
    localparam logic [ENTRY_W-1:0] SLOTS_E = ENTRY_W'(CLUSTER_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_SLOT);
    localparam logic [IDX_W:0] SLOTS_STEPS = (IDX_W+1)'(CLUSTER_SLOTS);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(2);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_LINK = 3'd4;
    localparam logic [2:0] S_FREE = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CFG_W-1:0]   cc_reg, cc_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   want_reg, want_next;
    logic [IDX_W:0]     steps_reg, steps_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [ENTRY_W-1:0] val_reg, val_next;
    rsp_t               out_reg, out_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
    logic [ENTRY_W-1:0] rdata;

    logic               idx_ok;
    logic [IDX_W-1:0]   cl_idx;
    logic [CNT_W-1:0]   cc_p1;
    logic [IDX_W-1:0]   lim;
    logic [CNT_W-1:0]   len_p1;
    logic [IDX_W-1:0]   seg_begin;
    logic [IDX_W:0]     steps_p1;

    cct_ram #(
        .DEPTH  (CLUSTER_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

    assign idx_ok = (req.cluster >= FIRST_DATA) && (req.cluster < SLOTS_E);
    assign cl_idx = req.cluster[IDX_W-1:0];
    assign cc_p1 = {1'b0, cc_reg} + CNT_W'(1);
    assign lim = (32'(cc_p1) > LAST_SLOT) ? LAST_IDX : IDX_W'(cc_p1);
    assign len_p1 = len_reg + CNT_W'(1);
    assign seg_begin = (len_reg == '0) ? cur_reg : start_reg;
    assign steps_p1 = steps_reg + (IDX_W+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        cc_next = cfg_valid ? cfg_data : cc_reg;
        clr_next = clr_reg;
        out_valid_next = out_valid_reg;
        cur_next = cur_reg;
        start_next = start_reg;
        last_next = last_reg;
        len_next = len_reg;
        want_next = want_reg;
        steps_next = steps_reg;
        stat_next = stat_reg;
        val_next = val_reg;
        out_next = out_reg;
        we = 1'b0;
        waddr = cur_reg;
        wdata = '0;
        raddr = cur_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    val_next = '0;
                    stat_next = STAT_OK;
                    state_next = S_RESP;
                    case (req.op)
                        OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                raddr = cl_idx;
                                state_next = S_RD;
                            end
                            else
                            begin
                                stat_next = STAT_BAD_ARG;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                we = 1'b1;
                                waddr = cl_idx;
                                wdata = req.entry_value;
                            end
                            else
                            begin
                                stat_next = STAT_BAD_ARG;
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (req.run_count == '0 || cc_reg == '0)
                            begin
                                stat_next = STAT_NO_SPACE;
                            end
                            else
                            begin
                                raddr = FIRST_IDX;
                                cur_next = FIRST_IDX;
                                len_next = '0;
                                want_next = req.run_count;
                                last_next = lim;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (idx_ok)
                            begin
                                raddr = cl_idx;
                                cur_next = cl_idx;
                                steps_next = '0;
                                state_next = S_FREE;
                            end
                            else
                            begin
                                stat_next = STAT_BAD_ARG;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                stat_next = STAT_OK;
                val_next = rdata;
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                // rdata holds the entry of cur_reg; the next entry is already requested
                raddr = (cur_reg == last_reg) ? cur_reg : cur_reg + IDX_W'(1);
                cur_next = cur_reg + IDX_W'(1);
                if (rdata != '0)
                begin
                    len_next = '0;
                    if (cur_reg == last_reg)
                    begin
                        stat_next = STAT_NO_SPACE;
                        state_next = S_RESP;
                    end
                end
                else if (len_p1 == want_reg)
                begin
                    start_next = seg_begin;
                    cur_next = seg_begin;
                    len_next = want_reg;
                    state_next = S_LINK;
                end
                else
                begin
                    start_next = seg_begin;
                    len_next = len_p1;
                    if (cur_reg == last_reg)
                    begin
                        stat_next = STAT_NO_SPACE;
                        state_next = S_RESP;
                    end
                end
            end
            S_LINK:
            begin
                we = 1'b1;
                waddr = cur_reg;
                cur_next = cur_reg + IDX_W'(1);
                len_next = len_reg - CNT_W'(1);
                if (len_reg == CNT_W'(1))
                begin
                    wdata = END_MARK;
                    stat_next = STAT_OK;
                    val_next = ENTRY_W'(start_reg);
                    state_next = S_RESP;
                end
                else
                begin
                    wdata = ENTRY_W'(cur_reg + IDX_W'(1));
                end
            end
            S_FREE:
            begin
                // clear this link and request the next one in the same cycle
                we = 1'b1;
                waddr = cur_reg;
                if (rdata < FIRST_DATA || rdata >= END_MARK)
                begin
                    stat_next = STAT_OK;
                    state_next = S_RESP;
                end
                else if (rdata >= SLOTS_E || steps_p1 >= SLOTS_STEPS)
                begin
                    stat_next = STAT_CHAIN;
                    state_next = S_RESP;
                end
                else
                begin
                    raddr = rdata[IDX_W-1:0];
                    cur_next = rdata[IDX_W-1:0];
                    steps_next = steps_p1;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.status = stat_reg;
                    out_next.cluster_result = val_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cc_reg <= '0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cc_reg <= cc_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        start_reg <= start_next;
        last_reg <= last_next;
        len_reg <= len_next;
        want_reg <= want_next;
        steps_reg <= steps_next;
        stat_reg <= stat_next;
        val_reg <= val_next;
        out_reg <= out_next;
    end

endmodule

// ===== src/cct_ram.sv =====
// single-port-write, single-port-read table memory with a registered read
// write-to-read bypass when both hit the same entry in the same cycle; uses cct_pkg
module cct_ram #(
    parameter int DEPTH = cct_pkg::DEF_CLUSTER_SLOTS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [cct_pkg::ENTRY_W-1:0] wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [cct_pkg::ENTRY_W-1:0] rdata
);
    import cct_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] q_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic               byp_reg;
    logic               byp_next;

    assign byp_next = we && (waddr == raddr);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
        byp_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    assign rdata = byp_reg ? byp_data_reg : q_reg;

endmodule
